// File: rtl/ucv_pkg.sv
// shared types and constants for the uri component validator
package ucv_pkg;

	// grammar selector codes
	typedef enum logic [2:0] {
		MODE_ABS_PATH = 3'd0,
		MODE_SEGMENT  = 3'd1,
		MODE_QUERY    = 3'd2,
		MODE_REG_NAME = 3'd3,
		MODE_TOKEN    = 3'd4,
		MODE_IPV4     = 3'd5
	} ucv_mode_t;

	localparam int unsigned MODE_W = 3;
	localparam logic [MODE_W-1:0] MODE_RESET = MODE_ABS_PATH;

	// register index of grammar_mode
	localparam logic REG_GRAMMAR_MODE = 1'b0;

	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_COLON = 8'h3A;

	localparam logic [9:0] OCTET_MAX = 10'd255;

	// byte class flags
	typedef struct packed {
		logic digit;
		logic alnum;
		logic hex;
		logic unreserved;
		logic sub_delim;
		logic tchar;
		logic pct;
		logic slash;
		logic dot;
		logic qmark;
		logic colon_at;
	} ucv_class_t;

	// per-string state
	typedef struct packed {
		logic       failed;
		logic [1:0] hex_pending;
		logic       at_first_byte;
		logic       after_slash;
		logic [1:0] dots_seen;
		logic [1:0] group_digits;
		logic [9:0] group_value;
	} ucv_state_t;

	localparam ucv_state_t STATE_RESET = '{
		failed:        1'b0,
		hex_pending:   2'd0,
		at_first_byte: 1'b1,
		after_slash:   1'b0,
		dots_seen:     2'd0,
		group_digits:  2'd0,
		group_value:   10'd0
	};

endpackage

// File: rtl/uri_component_validator_unit.sv
// top level of the uri component validator: input stage, string state, result register
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  in      | request   | in_valid/in_stall  | data_byte, last, empty_string
//  out     | result    | out_valid/out_stall| valid_res
//  apb     | config    | psel/penable/pready| grammar_mode at byte address 0
//
// one byte per cycle sustained: a request is registered in the input stage, and
// the classifier plus state update form the single logic level in front of the
// string state and result registers. the verdict is registered as a string's
// last request leaves the input stage. the input stage stalls only when it holds a
// string-ending request while the result register is full and stalled downstream.
// reset clears the grammar selector to absolute path and the string state.
module uri_component_validator_unit
	import ucv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// byte requests
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last,
	input  logic        empty_string,
	// verdicts
	output logic        out_valid,
	input  logic        out_stall,
	output logic        valid_res,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [MODE_W-1:0] mode_q;

	// input stage
	logic       valid_s1;
	logic [7:0] data_byte_s1;
	logic       last_s1;
	logic       empty_s1;

	ucv_state_t st_q;
	ucv_state_t st_next;
	ucv_class_t cls;
	logic       verdict;
	logic       ends_s1;
	logic       out_free;
	logic       adv_s1;
	logic       accept;
	logic       out_valid_q;
	logic       valid_res_q;

	// apb: register index is paddr[2], byte offset ignored
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_GRAMMAR_MODE) ? {{(32-MODE_W){1'b0}}, mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_GRAMMAR_MODE)) begin
			mode_q <= pwdata[MODE_W-1:0];
		end
	end

	// handshake: the stage advances unless its verdict has nowhere to go
	assign ends_s1  = empty_s1 || last_s1;
	assign out_free = !out_valid_q || !out_stall;
	assign adv_s1   = valid_s1 && (!ends_s1 || out_free);
	assign in_stall = valid_s1 && !adv_s1;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_byte_s1 <= data_byte;
			last_s1      <= last;
			empty_s1     <= empty_string;
		end
	end

	ucv_char_class u_class (
		.data_byte (data_byte_s1),
		.cls       (cls)
	);

	ucv_step u_step (
		.mode         (mode_q),
		.cls          (cls),
		.digit_val    (data_byte_s1[3:0]),
		.empty_string (empty_s1),
		.ends         (ends_s1),
		.cur          (st_q),
		.nxt          (st_next),
		.verdict      (verdict)
	);

	// string state, back to reset after each verdict
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_RESET;
		end else if (adv_s1) begin
			st_q <= st_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && ends_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && ends_s1) begin
			valid_res_q <= verdict;
		end
	end

	assign out_valid = out_valid_q;
	assign valid_res = valid_res_q;

endmodule

// File: rtl/ucv_char_class.sv
// byte classifier: ascii character classes used by the grammars
module ucv_char_class
	import ucv_pkg::*;
(
	input  logic [7:0] data_byte,
	output ucv_class_t cls
);

	logic is_digit, is_lower, is_upper;

	always_comb begin
		is_digit = (data_byte >= 8'h30) && (data_byte <= 8'h39);
		is_lower = (data_byte >= 8'h61) && (data_byte <= 8'h7A);
		is_upper = (data_byte >= 8'h41) && (data_byte <= 8'h5A);

		cls.digit = is_digit;
		cls.alnum = is_digit || is_lower || is_upper;
		cls.hex   = is_digit || ((data_byte >= 8'h61) && (data_byte <= 8'h66))
			|| ((data_byte >= 8'h41) && (data_byte <= 8'h46));
		// - . _ ~
		cls.unreserved = cls.alnum || (data_byte inside {8'h2D, 8'h2E, 8'h5F, 8'h7E});
		// ! $ & ' ( ) * + , ; =
		cls.sub_delim = data_byte inside {8'h21, 8'h24, [8'h26:8'h2C], 8'h3B, 8'h3D};
		// ! # $ % & ' * + - . ^ _ ` | ~
		cls.tchar = cls.alnum || (data_byte inside {8'h21, [8'h23:8'h27], 8'h2A, 8'h2B,
			8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E});
		cls.pct      = (data_byte == CH_PCT);
		cls.slash    = (data_byte == CH_SLASH);
		cls.dot      = (data_byte == CH_DOT);
		cls.qmark    = (data_byte == CH_QMARK);
		cls.colon_at = (data_byte == CH_COLON) || (data_byte == CH_AT);
	end

endmodule

// File: rtl/ucv_step.sv
// per-byte state update and end-of-string verdict
module ucv_step
	import ucv_pkg::*;
(
	input  logic [MODE_W-1:0] mode,
	input  ucv_class_t        cls,
	input  logic [3:0]        digit_val,
	input  logic              empty_string,
	input  logic              ends,
	input  ucv_state_t        cur,
	output ucv_state_t        nxt,
	output logic              verdict
);

	ucv_state_t upd;
	ucv_state_t eval;
	logic [9:0] times_ten;

	always_comb begin
		upd = cur;
		upd.at_first_byte = 1'b0;
		times_ten = {cur.group_value[6:0], 3'b000} + {cur.group_value[8:0], 1'b0};

		if (cur.hex_pending != 2'd0) begin
			if (!cls.hex) begin
				upd.failed = 1'b1;
			end
			upd.hex_pending = cur.hex_pending - 2'd1;
		end else begin
			case (mode)
				MODE_ABS_PATH: begin
					if (cur.at_first_byte) begin
						if (!cls.slash) upd.failed = 1'b1;
						else upd.after_slash = 1'b1;
					end else if (cls.slash) begin
						if (cur.after_slash) upd.failed = 1'b1;
						upd.after_slash = 1'b1;
					end else begin
						upd.after_slash = 1'b0;
						if (cls.pct) upd.hex_pending = 2'd2;
						else if (!(cls.unreserved || cls.sub_delim || cls.colon_at))
							upd.failed = 1'b1;
					end
				end
				MODE_SEGMENT: begin
					if (cls.pct) upd.hex_pending = 2'd2;
					else if (!(cls.unreserved || cls.sub_delim || cls.colon_at))
						upd.failed = 1'b1;
				end
				MODE_QUERY: begin
					if (!(cls.slash || cls.qmark)) begin
						if (cls.pct) upd.hex_pending = 2'd2;
						else if (!(cls.unreserved || cls.sub_delim || cls.colon_at))
							upd.failed = 1'b1;
					end
				end
				MODE_REG_NAME: begin
					if (cls.pct) upd.hex_pending = 2'd2;
					else if (!(cls.unreserved || cls.sub_delim)) upd.failed = 1'b1;
				end
				MODE_TOKEN: begin
					if (!cls.tchar) upd.failed = 1'b1;
				end
				MODE_IPV4: begin
					if (cls.digit) begin
						if (cur.group_digits == 2'd3) begin
							upd.failed = 1'b1;
						end else begin
							// at most two digits so far, so the value stays below 1000
							upd.group_value  = times_ten + {6'd0, digit_val};
							upd.group_digits = cur.group_digits + 2'd1;
							if (upd.group_value > OCTET_MAX) upd.failed = 1'b1;
						end
					end else if (cls.dot) begin
						if ((cur.group_digits == 2'd0) || (cur.dots_seen == 2'd3)) begin
							upd.failed = 1'b1;
						end else begin
							upd.dots_seen    = cur.dots_seen + 2'd1;
							upd.group_digits = 2'd0;
							upd.group_value  = 10'd0;
						end
					end else begin
						upd.failed = 1'b1;
					end
				end
				default: upd.failed = 1'b1;
			endcase
		end

		// an empty mark consumes nothing
		eval = empty_string ? cur : upd;

		if (eval.failed || (eval.hex_pending != 2'd0)) begin
			verdict = 1'b0;
		end else begin
			case (mode)
				MODE_ABS_PATH: verdict = !eval.at_first_byte;
				MODE_SEGMENT, MODE_QUERY, MODE_REG_NAME, MODE_TOKEN: verdict = 1'b1;
				MODE_IPV4: verdict = (eval.dots_seen == 2'd3) && (eval.group_digits != 2'd0)
					&& (eval.group_value <= OCTET_MAX);
				default: verdict = 1'b0;
			endcase
		end

		nxt = ends ? STATE_RESET : eval;
	end

endmodule
